FILE: hdl/mtc_pkg.sv
// shared widths, corner and sign-case tables and queue types for the cube contour unit
package mtc_pkg;

  localparam int GRID_BITS  = 8;
  localparam int FRAC_BITS  = 8;
  localparam int VALUE_BITS = 16;

  localparam int OUT_W  = GRID_BITS + FRAC_BITS + 1;
  localparam int NUM_W  = VALUE_BITS + FRAC_BITS + 1;
  localparam int DSR_W  = VALUE_BITS + 1;
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int IN_W   = 3 * GRID_BITS + 8 * VALUE_BITS;
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_DW = 9 * OUT_W;
  localparam int OUT_TW = ((OUT_DW + 7) / 8) * 8;
  localparam int NUM_TET = 5;

  localparam logic [2:0] TET_ODD [NUM_TET][4] = '{
    '{3'd0, 3'd6, 3'd3, 3'd2}, '{3'd0, 3'd5, 3'd6, 3'd4}, '{3'd5, 3'd3, 3'd6, 3'd7},
    '{3'd0, 3'd3, 3'd5, 3'd1}, '{3'd0, 3'd6, 3'd5, 3'd3}
  };
  localparam logic [2:0] TET_EVEN [NUM_TET][4] = '{
    '{3'd4, 3'd2, 3'd1, 3'd0}, '{3'd4, 3'd7, 3'd2, 3'd6}, '{3'd4, 3'd1, 3'd7, 3'd5},
    '{3'd1, 3'd2, 3'd7, 3'd3}, '{3'd4, 3'd2, 3'd7, 3'd1}
  };

  localparam logic [1:0] CASE_COUNT [16] = '{
    2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1,
    2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0
  };

  // edge code is {tet vertex a, tet vertex b}; unused slots hold zero
  localparam logic [3:0] CASE_EDGES [16][6] = '{
    '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0},
    '{4'h3, 4'hb, 4'h7, 4'h0, 4'h0, 4'h0},
    '{4'h2, 4'h6, 4'he, 4'h0, 4'h0, 4'h0},
    '{4'h7, 4'h3, 4'h2, 4'h7, 4'h2, 4'h6},
    '{4'h4, 4'h7, 4'h6, 4'h0, 4'h0, 4'h0},
    '{4'h1, 4'h3, 4'he, 4'h1, 4'he, 4'h9},
    '{4'h1, 4'hd, 4'he, 4'he, 4'h2, 4'h1},
    '{4'h1, 4'h3, 4'h2, 4'h0, 4'h0, 4'h0},
    '{4'h1, 4'h2, 4'h3, 4'h0, 4'h0, 4'h0},
    '{4'h1, 4'h2, 4'he, 4'h1, 4'he, 4'hd},
    '{4'h3, 4'h1, 4'hb, 4'h1, 4'h9, 4'hb},
    '{4'h1, 4'h9, 4'hd, 4'h0, 4'h0, 4'h0},
    '{4'h3, 4'h7, 4'h2, 4'h7, 4'h6, 4'h2},
    '{4'h2, 4'he, 4'h6, 4'h0, 4'h0, 4'h0},
    '{4'h3, 4'h7, 4'hb, 4'h0, 4'h0, 4'h0},
    '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0}
  };

  typedef struct packed {
    logic [2:0][GRID_BITS-1:0]  base;
    logic [7:0][VALUE_BITS-1:0] val;
    logic                       odd;
    logic [NUM_TET-1:0][3:0]    cs;
  } mtc_cube_t;

endpackage

FILE: hdl/mtc_front.sv
// front end: cube acceptance, parity and per-tetrahedron sign classification, cube queue
module mtc_front import mtc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IN_W-1:0]  in_data,
  output logic             head_valid,
  output mtc_cube_t        head,
  input  logic             head_pop
);

  mtc_cube_t  cls;
  mtc_cube_t  q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  always_comb begin
    logic [2:0] c;
    logic [GRID_BITS+1:0] sum;
    cls = '0;
    for (int a = 0; a < 3; a++) cls.base[a] = in_data[a*GRID_BITS +: GRID_BITS];
    for (int n = 0; n < 8; n++) cls.val[n] = in_data[3*GRID_BITS + n*VALUE_BITS +: VALUE_BITS];
    sum = (GRID_BITS+2)'(cls.base[0]) + (GRID_BITS+2)'(cls.base[1])
        + (GRID_BITS+2)'(cls.base[2]);
    cls.odd = sum[0];
    for (int t = 0; t < NUM_TET; t++) begin
      for (int v = 0; v < 4; v++) begin
        c = cls.odd ? TET_ODD[t][v] : TET_EVEN[t][v];
        cls.cs[t][3-v] = cls.val[c][VALUE_BITS-1];
      end
    end
  end

  assign in_ready   = (cnt_r != 2'd2);
  assign push       = in_valid && in_ready;
  assign head_valid = (cnt_r != 2'd0);
  assign pop        = head_pop && head_valid;
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cls;
  end

endmodule

FILE: hdl/mtc_back.sv
// back end: triangle sequencer, pipelined edge interpolation and output register
module mtc_back import mtc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  mtc_cube_t         head,
  output logic              head_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_DW-1:0] out_data,
  output logic              out_last
);

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DSR_W-1:0] dsr;
    logic [Q_W-1:0]   q;
    logic [2:0]       cn;
    logic [2:0]       cp;
  } vtx_t;

  typedef struct packed {
    vtx_t [2:0]                v;
    logic [2:0][GRID_BITS-1:0] base;
    logic                      last;
  } tri_t;

  logic [2:0]  tet_r, tet_nxt;
  logic        tri_r, tri_nxt;
  tri_t        pipe_r [Q_W+1];
  logic        vld_r  [Q_W+1];
  tri_t        pipe_nxt [Q_W+1];
  tri_t        setup_nxt;
  logic        out_valid_r;
  logic [OUT_DW-1:0] out_data_r, out_data_nxt;
  logic        out_last_r;
  logic        en;

  logic [2:0]  sel;
  logic        any_sel, more_after, last_tri, issue;
  logic [1:0]  cnt [NUM_TET];

  assign en = !out_valid_r || out_ready;

  // pick the next tetrahedron that still has triangles to give
  always_comb begin
    logic found;
    found = 1'b0;
    sel = 3'd0;
    more_after = 1'b0;
    for (int t = 0; t < NUM_TET; t++) begin
      cnt[t] = CASE_COUNT[head.cs[t]];
      if (cnt[t] != 2'd0 && 3'(t) >= tet_r) begin
        if (found) more_after = 1'b1;
        else begin
          found = 1'b1;
          sel = 3'(t);
        end
      end
    end
    any_sel  = found;
    last_tri = (tri_r || cnt[sel] == 2'd1) && !more_after;
    issue    = head_valid && en && any_sel;
    head_pop = head_valid && en && (!any_sel || last_tri);
    tet_nxt  = tet_r;
    tri_nxt  = tri_r;
    if (head_pop) begin
      tet_nxt = 3'd0;
      tri_nxt = 1'b0;
    end else if (issue) begin
      if (!tri_r && cnt[sel] == 2'd2) begin
        tet_nxt = sel;
        tri_nxt = 1'b1;
      end else begin
        tet_nxt = sel + 3'd1;
        tri_nxt = 1'b0;
      end
    end
  end

  // vertex set-up: interpolation always runs from the negative corner
  always_comb begin
    logic [3:0] e;
    logic [2:0] ca, cb, cn, cp;
    logic [VALUE_BITS-1:0] mn, mp, den;
    logic [2:0] idx;
    setup_nxt = '0;
    setup_nxt.base = head.base;
    setup_nxt.last = last_tri;
    for (int v = 0; v < 3; v++) begin
      idx = tri_r ? 3'(3 + v) : 3'(v);
      e  = CASE_EDGES[head.cs[sel]][idx];
      ca = head.odd ? TET_ODD[sel][e[3:2]] : TET_EVEN[sel][e[3:2]];
      cb = head.odd ? TET_ODD[sel][e[1:0]] : TET_EVEN[sel][e[1:0]];
      if (!head.val[ca][VALUE_BITS-1]) begin
        cn = cb;
        cp = ca;
      end else begin
        cn = ca;
        cp = cb;
      end
      mn  = ~head.val[cn] + 1'b1;
      mp  = head.val[cp];
      den = mn + mp;
      setup_nxt.v[v].rem = {mn, {(FRAC_BITS+1){1'b0}}} + NUM_W'(den);
      setup_nxt.v[v].dsr = {den, 1'b0};
      setup_nxt.v[v].q   = '0;
      setup_nxt.v[v].cn  = cn;
      setup_nxt.v[v].cp  = cp;
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [NUM_W-1:0] sub;
    pipe_nxt[0] = setup_nxt;
    for (int k = 0; k < Q_W; k++) begin
      pipe_nxt[k+1] = pipe_r[k];
      for (int v = 0; v < 3; v++) begin
        sub = NUM_W'(pipe_r[k].v[v].dsr) << (Q_W - 1 - k);
        if (pipe_r[k].v[v].rem >= sub) begin
          pipe_nxt[k+1].v[v].rem = pipe_r[k].v[v].rem - sub;
          pipe_nxt[k+1].v[v].q[Q_W-1-k] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic [GRID_BITS:0] an, ap;
    logic [OUT_W-1:0]   pos;
    out_data_nxt = '0;
    for (int v = 0; v < 3; v++) begin
      for (int a = 0; a < 3; a++) begin
        an  = (GRID_BITS+1)'(pipe_r[Q_W].base[a]) + (GRID_BITS+1)'(pipe_r[Q_W].v[v].cn[2-a]);
        ap  = (GRID_BITS+1)'(pipe_r[Q_W].base[a]) + (GRID_BITS+1)'(pipe_r[Q_W].v[v].cp[2-a]);
        pos = {an, {FRAC_BITS{1'b0}}};
        if (ap > an)      pos = pos + OUT_W'(pipe_r[Q_W].v[v].q);
        else if (ap < an) pos = pos - OUT_W'(pipe_r[Q_W].v[v].q);
        out_data_nxt[(3*v+a)*OUT_W +: OUT_W] = pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tet_r       <= 3'd0;
      tri_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= Q_W; k++) vld_r[k] <= 1'b0;
    end else begin
      tet_r <= tet_nxt;
      tri_r <= tri_nxt;
      if (en) begin
        vld_r[0] <= issue;
        for (int k = 0; k < Q_W; k++) vld_r[k+1] <= vld_r[k];
        out_valid_r <= vld_r[Q_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= Q_W; k++) pipe_r[k] <= pipe_nxt[k];
      out_data_r <= out_data_nxt;
      out_last_r <= pipe_r[Q_W].last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

FILE: hdl/marching_tets_cube_contour_unit.sv
// top level of the cube contour unit: front classifier and queue, back interpolation pipeline
// path: a triangle passes the set-up register, 9 division stages and the output register after its
//   cube is taken (the queue write shares the accepting edge), and stalls while out_tready is low
// throughput: one triangle per cycle while out_tready does not stall the pipeline; a cube holds the
//   queue head until its last triangle is issued, and a cube with no triangle is popped without one
// reset: synchronous active-low rst_n empties the queue, the sequencer and the pipeline
module marching_tets_cube_contour_unit import mtc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // cube_i, cube_j, cube_k, val_000, val_001, val_010, val_011, val_100 .. val_111
  input  logic [IN_TW-1:0]  in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // vert0_x, vert0_y, vert0_z, vert1_x .. vert2_z, zero fill
  output logic [OUT_TW-1:0] out_tdata,
  output logic              out_tlast
);

  logic              head_valid, head_pop;
  mtc_cube_t         head;
  logic [OUT_DW-1:0] out_data;

  mtc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata[IN_W-1:0]),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  mtc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_data),
    .out_last   (out_tlast)
  );

  assign out_tdata = OUT_TW'(out_data);

endmodule

FILE: test/testbench.sv
// testbench for the cube contour unit: directed table, random cubes, triangle predictor
module testbench import mtc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;
  localparam int GW = GRID_BITS;
  localparam int VW = VALUE_BITS;

  typedef struct packed {
    logic [8:0][OUT_W-1:0] vert;   // index 0 = vert0_x
    logic                  last;
  } tri_t;

  typedef struct {
    logic [GW-1:0] ci, cj, ck;
    logic [7:0][VW-1:0] v;
    bit            chk_first;      // typed-in expectation for the first triangle
    bit            none;           // typed-in: no triangle at all
    logic [8:0][OUT_W-1:0] first;
  } cube_row_t;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0;
  logic [IN_TW-1:0] in_tdata = '0;
  logic in_tready, out_tvalid, out_tlast;
  logic [OUT_TW-1:0] out_tdata;

  tri_t triangles_due[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stall_long = 0;

  marching_tets_cube_contour_unit uut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  function automatic logic [OUT_W-1:0] axis(logic [OUT_W-1:0] an, logic [OUT_W-1:0] ap,
                                            logic [OUT_W-1:0] t);
    logic [OUT_W-1:0] b;
    b = an << FRAC_BITS;
    if (ap > an) b = b + t;
    else if (ap < an) b = b - t;
    return b;
  endfunction

  // x, y, z of the crossing on the edge between cube corners ca and cb, x lowest
  function automatic logic [3*OUT_W-1:0] crossing(logic [GW-1:0] bs[3], int signed vals[8],
                                                  int ca, int cb);
    int cn, cp;
    longint mn, mp, den, num, t;
    logic [3*OUT_W-1:0] p;
    cn = ca; cp = cb;
    if (vals[ca] >= 0) begin cn = cb; cp = ca; end
    mn = -vals[cn];
    mp = vals[cp] >= 0 ? vals[cp] : 0;
    den = mn + mp;
    if (den == 0) den = 1;
    num = mn << FRAC_BITS;
    t = (2 * num + den) / (2 * den);
    p = '0;
    for (int ax = 0; ax < 3; ax++)
      p[ax*OUT_W +: OUT_W] = axis(OUT_W'(int'(bs[ax]) + ((cn >> (2-ax)) & 1)),
                                  OUT_W'(int'(bs[ax]) + ((cp >> (2-ax)) & 1)), OUT_W'(t));
    return p;
  endfunction

  // fills the triangle queue for one cube, returns the triangle count
  function automatic int predict_cube(cube_row_t r);
    logic [GW-1:0] bs[3];
    int signed vals[8];
    int n, cs, e, pos;
    logic [2:0] corn[4];
    logic [3*OUT_W-1:0] p3;
    bit odd;
    tri_t tr;
    n = 0;
    pos = triangles_due.size();
    bs[0] = r.ci; bs[1] = r.cj; bs[2] = r.ck;
    for (int c = 0; c < 8; c++) vals[c] = $signed(r.v[c]);
    odd = 1'((int'(r.ci) + int'(r.cj) + int'(r.ck)) % 2);
    for (int tt = 0; tt < NUM_TET; tt++) begin
      for (int q = 0; q < 4; q++) corn[q] = odd ? TET_ODD[tt][q] : TET_EVEN[tt][q];
      cs = 0;
      for (int q = 0; q < 4; q++) if (vals[corn[q]] < 0) cs |= 1 << (3 - q);
      for (int k = 0; k < int'(CASE_COUNT[cs]); k++) begin
        tr = '0;
        for (int q = 0; q < 3; q++) begin
          e = int'(CASE_EDGES[cs][k*3+q]);
          p3 = crossing(bs, vals, int'(corn[e>>2]), int'(corn[e&3]));
          for (int ax = 0; ax < 3; ax++) tr.vert[q*3+ax] = p3[ax*OUT_W +: OUT_W];
        end
        triangles_due = {triangles_due, tr};
        n++;
      end
    end
    if (n > 0) triangles_due[$].last = 1;
    if (r.chk_first && n > 0 && triangles_due[pos].vert != r.first) begin
      $error("typed row mismatch: expected %h predictor %h", r.first, triangles_due[pos].vert);
      errors++;
    end
    if (r.none && n != 0) begin
      $error("typed row: expected no triangle, predictor gave %0d", n);
      errors++;
    end
    return n;
  endfunction

  function automatic cube_row_t mk(int i, int j, int k, int v0, int v1, int v2, int v3,
                                   int v4, int v5, int v6, int v7);
    cube_row_t r;
    r.ci = GW'(i); r.cj = GW'(j); r.ck = GW'(k);
    r.v[0] = VW'(v0); r.v[1] = VW'(v1); r.v[2] = VW'(v2); r.v[3] = VW'(v3);
    r.v[4] = VW'(v4); r.v[5] = VW'(v5); r.v[6] = VW'(v6); r.v[7] = VW'(v7);
    r.chk_first = 0; r.none = 0; r.first = '0;
    return r;
  endfunction

  task automatic send_cube(cube_row_t r);
    int gap;
    gap = $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    void'(predict_cube(r));
    in_tdata <= {r.v, r.ck, r.cj, r.ci};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [VW-1:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return VW'($urandom());
    endcase
  endfunction

  // result side
  initial begin
    int gap;
    tri_t exp_tri;
    @(posedge rst_n);
    forever begin
      if (stall_long) begin
        out_tready <= 0;
        repeat (300) @(posedge clk);
        stall_long = 0;
      end
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      if (triangles_due.size() == 0) begin
        $error("triangle with no expectation waiting: %h", out_tdata);
        errors++;
      end else begin
        exp_tri = triangles_due.pop_front();
        for (int f = 0; f < 9; f++)
          if (out_tdata[f*OUT_W +: OUT_W] !== exp_tri.vert[f]) begin
            $error("vert%0d_%s expected %0d actual %0d", f/3, f%3==0 ? "x" : f%3==1 ? "y" : "z",
                   exp_tri.vert[f], out_tdata[f*OUT_W +: OUT_W]);
            errors++;
          end
        if (out_tlast !== exp_tri.last) begin
          $error("last_triangle expected %0d actual %0d", exp_tri.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer accepted on either the input or the output side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    cube_row_t dir[$];
    cube_row_t r;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // all same sign class: nothing
    r = mk(0, 0, 0, 5, 5, 5, 5, 5, 5, 5, 5); r.none = 1; dir = {dir, r};
    r = mk(255, 255, 255, -1, -1, -1, -1, -1, -1, -1, -1); r.none = 1; dir = {dir, r};
    r = mk(3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); r.none = 1; dir = {dir, r};
    r = mk(0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
           16'h8000, 16'h8000); r.none = 1; dir = {dir, r};
    // single negative corner: even parity with zeros elsewhere (vertices at the zero corners), then odd parity
    r = mk(0, 0, 0, -1, 0, 0, 0, 0, 0, 0, 0); dir = {dir, r};
    r = mk(1, 0, 0, -100, 100, 100, 100, 100, 100, 100, 100); dir = {dir, r};
    // upper grid edge, extreme values, then mixed-sign patterns
    r = mk(255, 255, 255, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
           16'h7fff, 16'h8000); dir = {dir, r};
    r = mk(255, 0, 255, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
           16'h8000, 16'h7fff); dir = {dir, r};
    r = mk(254, 255, 0, -1, 1, -1, 1, -1, 1, -1, 1); dir = {dir, r};
    r = mk(128, 64, 32, -3, -3, 7, 7, -3, -3, 7, 7); dir = {dir, r};
    r = mk(17, 200, 99, 0, -1, 0, -1, 0, -1, 0, -1); dir = {dir, r};
    // every single negative corner, both parities
    for (int c = 0; c < 8; c++) begin
      r = mk(c, 0, 0, 9, 9, 9, 9, 9, 9, 9, 9);
      r.v[c] = VW'(-4);
      dir = {dir, r};
    end
    // typed expectation: base 0, only 000 negative with 1 at others, even tet 0 case 1
    // tet (100,010,001,000): edges 000-100, 000-001, 000-010, each with t = 128
    r = mk(0, 0, 0, -1, 1, 1, 1, 1, 1, 1, 1);
    r.chk_first = 1;
    r.first = '0;
    r.first[0] = 128; r.first[5] = 128; r.first[7] = 128;
    dir = {dir, r};

    foreach (dir[n]) send_cube(dir[n]);

    for (int n = 0; n < 200; n++) begin
      r = mk($urandom(), $urandom(), $urandom(), 0, 0, 0, 0, 0, 0, 0, 0);
      if ($urandom_range(0, 4) == 0) begin
        r.ci = GW'($urandom_range(0, 1) ? 255 : 0);
        r.cj = GW'($urandom_range(0, 1) ? 255 : 0);
      end
      for (int c = 0; c < 8; c++) r.v[c] = rnd_val();
      if (n == 60) stall_long = 1;
      if (n == 120) begin
        in_tvalid <= 0;
        @(posedge clk);
        while (triangles_due.size() != 0) @(posedge clk);
      end
      send_cube(r);
    end

    in_tvalid <= 0;
    @(posedge clk);
    while (triangles_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && triangles_due.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
